// File: rtl/core/heat_stencil_sweep_macros.svh
// Assertion macros for the heat stencil sweep block.
// Used by the top level; needs i_clk and i_rst_n in the including scope.
`ifndef HEAT_STENCIL_SWEEP_MACROS_SVH
`define HEAT_STENCIL_SWEEP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hss_pkg.sv
// Shared types, constants and helper functions of the heat stencil sweep block.
// No dependencies.
`timescale 1ns / 1ps

package hss_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_WEIGHT_X  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WEIGHT_Y  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BND_INC   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A0,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_PREP,
        S_MUL,
        S_RND,
        S_SQ,
        S_ACC,
        S_OUT1,
        S_OUT2
    } t_state;

    // Saturates a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] res;
        if (v > 38'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -38'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Boundary update: value plus increment, saturated.
    function automatic logic signed [31:0] bnd_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [37:0] s;
        s = 38'(a) + 38'(b);
        return sat32(s);
    endfunction

endpackage

// File: rtl/core/hss_row_mem.sv
// Two-row line buffer memory with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module hss_row_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [31:0]       i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/heat_stencil_sweep.sv
// Top level of the heat stencil sweep: one explicit time step of the 2D heat equation.
// Depends on hss_pkg, hss_row_mem and heat_stencil_sweep_macros.svh.
//
// Cells enter in raster order on the input channel (i_in_valid / o_in_ready,
// i_cell_value). Updated cells leave on the output channel (o_out_valid /
// i_out_ready) one row late; a cell of the last row also releases itself, so
// such a transaction yields two results. Row 0 yields none.
// Items are handled one at a time. An interior cell goes from acceptance to its
// result being loaded into the output register through S_A0 to S_A4 (four reads
// over the row memory's single read port), then the neighbor sums, the weight
// multiplies, rounding, squaring of the change and accumulation. A boundary
// cell reads only its old value and goes on to rounding and S_ACC, a row 0 cell
// goes straight to S_ACC, and a last-row cell then also loads its second result.
// The output register lets the next item start while a result waits; a stalled
// receiver holds the block only when a new result must be loaded. Configuration
// writes (i_cfg_we) take effect at once; the user must make them only while idle,
// which the block does not enforce. Reset clears the counters, the squared-change
// sum and the output valid and restores register defaults; the row memory needs none.
`timescale 1ns / 1ps

module heat_stencil_sweep #(
    parameter int MAX_COLS = hss_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = hss_pkg::DEF_MAX_ROWS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [hss_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [hss_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [31:0]         i_cell_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_row,
    output logic [7:0]                 o_out_col,
    output logic signed [31:0]         o_new_value,
    output logic [63:0]                o_diff_sum,
    output logic                       o_end_of_grid,
    output logic                       o_last_of_run
);

    import hss_pkg::*;
    `include "heat_stencil_sweep_macros.svh"

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int DEPTH = 2 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RDW   = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;
    localparam int CDW   = ($clog2(MAX_COLS + 1) > 9) ? $clog2(MAX_COLS + 1) : 9;
    localparam logic [AW-1:0] BANK_OFS = AW'(MAX_COLS);

    logic [8:0]         r_rows;
    logic [8:0]         r_cols;
    logic [14:0]        r_wx;
    logic [14:0]        r_wy;
    logic signed [31:0] r_binc;

    t_state r_state;
    t_state n_state;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_it_row;
    logic [CW-1:0] r_it_col;
    logic          r_first;
    logic          r_last_row;
    logic          r_last_col;
    logic          r_interior;
    logic          r_pr_one;
    logic          r_c_one;

    logic signed [31:0] r_cur;
    logic signed [31:0] r_old;
    logic signed [31:0] r_up;
    logic signed [31:0] r_left;
    logic signed [31:0] r_right;
    logic signed [34:0] r_sx;
    logic signed [34:0] r_sy;
    logic signed [50:0] r_px;
    logic signed [50:0] r_py;
    logic signed [31:0] r_nv;
    logic [63:0]        r_sq;
    logic [63:0]        r_acc;

    logic               r_o_valid;
    logic [7:0]         r_o_row;
    logic [7:0]         r_o_col;
    logic signed [31:0] r_o_value;
    logic [63:0]        r_o_diff;
    logic               r_o_eog;
    logic               r_o_last;

    logic [RDW-1:0] rows_eff;
    logic [CDW-1:0] cols_eff;
    logic           in_acc;
    logic           out_load;
    logic           last_row;
    logic           last_col;
    logic           interior;
    logic [AW-1:0]  here_base;
    logic [AW-1:0]  prev_base;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic [31:0]    rd_data;
    logic [RW+7:0]  row_wide_pr;
    logic [RW+7:0]  row_wide_r;
    logic [CW+7:0]  col_wide;

    logic signed [31:0] up_b;
    logic signed [31:0] left_b;
    logic signed [53:0] t_sum;
    logic signed [37:0] t_q;
    logic signed [32:0] d_val;
    logic [32:0]        d_abs;
    logic [64:0]        acc_sum;

    hss_row_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_row_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(r_cur),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 9'd30;
            r_cols <= 9'd30;
            r_wx   <= 15'd16384;
            r_wy   <= 15'd16384;
            r_binc <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_ROWS: r_rows <= i_cfg_data[8:0];
                CFG_GRID_COLS: r_cols <= i_cfg_data[8:0];
                CFG_WEIGHT_X:  r_wx   <= i_cfg_data[14:0];
                CFG_WEIGHT_Y:  r_wy   <= i_cfg_data[14:0];
                CFG_BND_INC:   r_binc <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (RDW'(r_rows) < RDW'(3)) begin
            rows_eff = RDW'(3);
        end else if (RDW'(r_rows) > RDW'(MAX_ROWS)) begin
            rows_eff = RDW'(MAX_ROWS);
        end else begin
            rows_eff = RDW'(r_rows);
        end
        if (CDW'(r_cols) < CDW'(3)) begin
            cols_eff = CDW'(3);
        end else if (CDW'(r_cols) > CDW'(MAX_COLS)) begin
            cols_eff = CDW'(MAX_COLS);
        end else begin
            cols_eff = CDW'(r_cols);
        end
    end

    assign last_row = ((RDW + 1)'(r_row) + 1'b1) >= (RDW + 1)'(rows_eff);
    assign last_col = ((CDW + 1)'(r_col) + 1'b1) >= (CDW + 1)'(cols_eff);
    assign interior = (r_row >= RW'(2)) && ((RDW + 1)'(r_row) < (RDW + 1)'(rows_eff))
                    && (r_col != '0) && !last_col;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = ((r_state == S_OUT1) || (r_state == S_OUT2))
                      && (!r_o_valid || i_out_ready);

    assign here_base = r_it_row[0] ? BANK_OFS : '0;
    assign prev_base = r_it_row[0] ? '0 : BANK_OFS;
    assign wr_addr   = here_base + AW'(r_it_col);
    assign wr_en     = (r_state == S_ACC);

    always_comb begin
        unique case (r_state)
            S_A1:    rd_addr = here_base + AW'(r_it_col);
            S_A2:    rd_addr = prev_base + AW'(r_it_col) - 1'b1;
            S_A3:    rd_addr = prev_base + AW'(r_it_col) + 1'b1;
            default: rd_addr = prev_base + AW'(r_it_col);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (r_row != '0) ? S_A0 : S_ACC;
                end
            end
            S_A0:   n_state = S_A1;
            S_A1:   n_state = r_interior ? S_A2 : S_RND;
            S_A2:   n_state = S_A3;
            S_A3:   n_state = S_A4;
            S_A4:   n_state = S_PREP;
            S_PREP: n_state = S_MUL;
            S_MUL:  n_state = S_RND;
            S_RND:  n_state = r_interior ? S_SQ : S_ACC;
            S_SQ:   n_state = S_ACC;
            S_ACC: begin
                priority if (r_first) begin
                    n_state = S_OUT1;
                end else if (r_last_row) begin
                    n_state = S_OUT2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT1: begin
                if (out_load) begin
                    n_state = r_last_row ? S_OUT2 : S_IDLE;
                end
            end
            S_OUT2: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        up_b    = r_pr_one ? bnd_add(r_up, r_binc) : r_up;
        left_b  = r_c_one ? bnd_add(r_left, r_binc) : r_left;
        t_sum   = (54'(r_old) <<< 16) + 54'(r_px) + 54'(r_py) + 54'sd32768;
        t_q     = t_sum[53:16];
        d_val   = 33'(r_old) - 33'(r_nv);
        d_abs   = d_val[32] ? 33'(-d_val) : 33'(d_val);
        acc_sum = {1'b0, r_acc} + {1'b0, r_sq};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_acc <= '0;
        end else begin
            if (r_state == S_ACC) begin
                if (r_first && r_interior) begin
                    r_acc <= acc_sum[64] ? '1 : acc_sum[63:0];
                end
                if (r_last_col) begin
                    r_col <= '0;
                    r_row <= r_last_row ? '0 : r_it_row + 1'b1;
                end else begin
                    r_col <= r_it_col + 1'b1;
                end
            end
            if ((r_state == S_OUT2) && out_load && r_last_col) begin
                r_acc <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur      <= i_cell_value;
            r_it_row   <= r_row;
            r_it_col   <= r_col;
            r_first    <= (r_row != '0);
            r_last_row <= last_row;
            r_last_col <= last_col;
            r_interior <= interior;
            r_pr_one   <= (r_row == RW'(2));
            r_c_one    <= (r_col == CW'(1));
        end
        unique case (r_state)
            S_A1:    r_old   <= rd_data;
            S_A2:    r_up    <= rd_data;
            S_A3:    r_left  <= rd_data;
            S_A4:    r_right <= rd_data;
            S_PREP: begin
                r_sx <= 35'(up_b) + 35'(r_cur) - (35'(r_old) <<< 1);
                r_sy <= 35'(left_b) + 35'(r_right) - (35'(r_old) <<< 1);
            end
            S_MUL: begin
                r_px <= 51'($signed({1'b0, r_wx}) * r_sx);
                r_py <= 51'($signed({1'b0, r_wy}) * r_sy);
            end
            S_RND:   r_nv <= r_interior ? sat32(t_q) : bnd_add(r_old, r_binc);
            S_SQ:    r_sq <= d_abs[32] ? '1 : 64'(d_abs[31:0]) * 64'(d_abs[31:0]);
            default: begin
            end
        endcase
    end

    assign row_wide_pr = {8'd0, r_it_row - 1'b1};
    assign row_wide_r  = {8'd0, r_it_row};
    assign col_wide    = {8'd0, r_it_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_col  <= col_wide[7:0];
            r_o_diff <= r_acc;
            if (r_state == S_OUT1) begin
                r_o_row   <= row_wide_pr[7:0];
                r_o_value <= r_nv;
                r_o_eog   <= 1'b0;
                r_o_last  <= !r_last_row;
            end else begin
                r_o_row   <= row_wide_r[7:0];
                r_o_value <= bnd_add(r_cur, r_binc);
                r_o_eog   <= r_last_col;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_row     = r_o_row;
    assign o_out_col     = r_o_col;
    assign o_new_value   = r_o_value;
    assign o_diff_sum    = r_o_diff;
    assign o_end_of_grid = r_o_eog;
    assign o_last_of_run = r_o_last;

    `HSS_ASSERT_NEXT(a_acc_cleared, (r_state == S_OUT2) && out_load && r_last_col,
        r_acc == '0, "sum of squared changes not cleared after the last cell")
    `HSS_ASSERT_NOW(a_eog_last, o_out_valid && o_end_of_grid, o_last_of_run,
        "end of grid on a result that is not the last of its transaction")
    `HSS_ASSERT_NOW(a_first_row, (r_state == S_OUT1) && out_load, r_it_row != '0,
        "delayed result emitted for a row 0 transaction")

endmodule
